// ===== sv/bbc_pkg.sv =====
// Package for the bracket balance checker.
// Holds lexer modes, quote kinds, result codes, character constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

  typedef enum logic [1:0] {
    MODE_CODE   = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_STRING = 2'd3
  } lex_mode_t;

  typedef enum logic [1:0] {
    QUOTE_SINGLE   = 2'd0,
    QUOTE_DOUBLE   = 2'd1,
    QUOTE_BACKTICK = 2'd2
  } quote_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNMATCHED = 2'd1,
    STATUS_OPEN      = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  localparam int NUM_KINDS   = 3;
  localparam int KIND_BRACE  = 0;
  localparam int KIND_PAREN  = 1;
  localparam int KIND_SQUARE = 2;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // one bit per bracket kind, indexed by KIND_*
  typedef struct packed {
    logic [NUM_KINDS-1:0] open;
    logic [NUM_KINDS-1:0] close;
  } bracket_evt_t;

  function automatic logic [7:0] quote_char(input quote_kind_t kind);
    logic [7:0] ch;
    unique case (kind)
      QUOTE_SINGLE:   ch = CH_SQUOTE;
      QUOTE_DOUBLE:   ch = CH_DQUOTE;
      QUOTE_BACKTICK: ch = CH_BACKTICK;
      default:        ch = CH_SQUOTE;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/bbc_if.sv =====
// Valid/ready channel interfaces for the bracket balance checker.
// Depends on nothing; payload widths are fixed by the byte and result formats.
`timescale 1ns / 1ps

interface bbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface bbc_result_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [1:0] status;

  modport source (output valid, output balanced, output status, input ready);
  modport sink   (input valid, input balanced, input status, output ready);
endinterface

// ===== sv/bracket_balance_checker.sv =====
// Bracket balance checker top level: input register, lexer, depth counters, result register.
// Depends on bbc_pkg, bbc_if, bbc_lexer and bbc_depth_counter.
//
// Usage:
//   byte_in carries one text byte per transfer; final_byte marks the last byte of a text.
//   result_out carries one result per text (balanced, status), made from the final byte.
//   Bytes in comments and quoted strings are skipped; a closer at depth zero or an
//   opener at MAX_DEPTH sets a sticky failure that is reported at the end of the text.
//   Throughput: one byte per cycle, except while a final byte is held (see Stall). Each byte
//   is held in the input register and folded into the lexer and counter state from there;
//   the whole per-byte update is combinational logic between those registers.
//   Result: the verdict enters the result register when the final byte leaves the input
//   register, and result_out.valid rises with it.
//   Stall: while a result waits in the output register, non-final bytes keep flowing;
//   a following final byte waits in the input register and holds off byte_in.ready.
//   Reset (rst, synchronous): clears all lexer state, counters, failure and valid flags.
//   After each final byte all state clears for the next text.
`timescale 1ns / 1ps

module bracket_balance_checker #(
  parameter int MAX_DEPTH = 255
) (
  input  logic          clk,
  input  logic          rst,
  bbc_byte_if.sink      byte_in,
  bbc_result_if.source  result_out
);
  import bbc_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_final;
  logic         advance;
  bracket_evt_t evt;

  logic [NUM_KINDS-1:0] nonzero_next;
  logic [NUM_KINDS-1:0] overflow;
  logic [NUM_KINDS-1:0] underflow;
  logic [DEPTH_W-1:0]   depth [NUM_KINDS];

  status_t fail, fail_next;
  status_t status_next;
  logic    out_valid;
  status_t out_status;

  assign advance       = in_valid && (!in_final || !out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte  <= byte_in.text_byte;
      in_final <= byte_in.final_byte;
    end
  end

  bbc_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .clear     (in_final),
    .text_byte (in_byte),
    .evt       (evt)
  );

  for (genvar k = 0; k < NUM_KINDS; k++) begin : g_depth
    bbc_depth_counter #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W)
    ) u_depth (
      .clk          (clk),
      .rst          (rst),
      .step         (advance),
      .clear        (in_final),
      .freeze       (fail != STATUS_OK),
      .open         (evt.open[k]),
      .close        (evt.close[k]),
      .depth        (depth[k]),
      .nonzero_next (nonzero_next[k]),
      .overflow     (overflow[k]),
      .underflow    (underflow[k])
    );
  end

  always_comb begin
    priority if (fail != STATUS_OK) fail_next = fail;
    else if (|overflow)             fail_next = STATUS_OVERFLOW;
    else if (|underflow)            fail_next = STATUS_UNMATCHED;
    else                            fail_next = STATUS_OK;

    priority if (fail_next != STATUS_OK) status_next = fail_next;
    else if (|nonzero_next)              status_next = STATUS_OPEN;
    else                                 status_next = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_final)) begin
      fail <= STATUS_OK;
    end else if (advance) begin
      fail <= fail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_final) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_final) begin
      out_status <= status_next;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.status   = out_status;
  assign result_out.balanced = (out_status == STATUS_OK);

`ifndef SYNTH
  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    advance && in_final |=> depth[KIND_BRACE] == '0 && depth[KIND_PAREN] == '0
                            && depth[KIND_SQUARE] == '0 && fail == STATUS_OK)
    else $error("state not cleared after final byte");

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    fail != STATUS_OK && !(advance && in_final) |=> fail == $past(fail))
    else $error("failure code changed within a text");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |-> !(advance && in_final))
    else $error("pending result overwritten");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth[KIND_BRACE] <= DEPTH_W'(MAX_DEPTH) && depth[KIND_PAREN] <= DEPTH_W'(MAX_DEPTH)
    && depth[KIND_SQUARE] <= DEPTH_W'(MAX_DEPTH))
    else $error("depth counter beyond limit");
`endif

endmodule

// ===== sv/bbc_lexer.sv =====
// Lexer state for the bracket balance checker: code, comments and strings.
// Emits at most one bracket open/close event per byte seen in code. Uses bbc_pkg.
`timescale 1ns / 1ps

module bbc_lexer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  clear,
  input  logic [7:0]            text_byte,
  output bbc_pkg::bracket_evt_t evt
);
  import bbc_pkg::*;

  lex_mode_t   mode, mode_next;
  quote_kind_t quote, quote_next;
  logic        slash_pending, slash_pending_next;
  logic        star_seen, star_seen_next;
  logic        prior_backslash;
  logic        code_en;

  always_comb begin
    mode_next          = mode;
    quote_next         = quote;
    slash_pending_next = slash_pending;
    star_seen_next     = star_seen;
    code_en            = 1'b0;
    evt                = '0;

    unique case (mode)
      MODE_LINE: begin
        if (text_byte == CH_NEWLINE) mode_next = MODE_CODE;
      end
      MODE_BLOCK: begin
        if (star_seen && text_byte == CH_SLASH) begin
          mode_next      = MODE_CODE;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (text_byte == CH_STAR);
        end
      end
      MODE_STRING: begin
        if (text_byte == quote_char(quote) && !prior_backslash) mode_next = MODE_CODE;
      end
      default: begin
        code_en = 1'b1;
        if (slash_pending) begin
          slash_pending_next = 1'b0;
          if (text_byte == CH_SLASH) begin
            mode_next = MODE_LINE;
            code_en   = 1'b0;
          end else if (text_byte == CH_STAR) begin
            mode_next      = MODE_BLOCK;
            star_seen_next = 1'b0;
            code_en        = 1'b0;
          end
        end
      end
    endcase

    if (code_en) begin
      unique case (text_byte)
        CH_SLASH:    slash_pending_next = 1'b1;
        CH_SQUOTE:   begin mode_next = MODE_STRING; quote_next = QUOTE_SINGLE;   end
        CH_DQUOTE:   begin mode_next = MODE_STRING; quote_next = QUOTE_DOUBLE;   end
        CH_BACKTICK: begin mode_next = MODE_STRING; quote_next = QUOTE_BACKTICK; end
        CH_LBRACE:   evt.open[KIND_BRACE]   = 1'b1;
        CH_RBRACE:   evt.close[KIND_BRACE]  = 1'b1;
        CH_LPAREN:   evt.open[KIND_PAREN]   = 1'b1;
        CH_RPAREN:   evt.close[KIND_PAREN]  = 1'b1;
        CH_LSQUARE:  evt.open[KIND_SQUARE]  = 1'b1;
        CH_RSQUARE:  evt.close[KIND_SQUARE] = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      mode            <= MODE_CODE;
      quote           <= QUOTE_SINGLE;
      slash_pending   <= 1'b0;
      star_seen       <= 1'b0;
      prior_backslash <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      quote           <= quote_next;
      slash_pending   <= slash_pending_next;
      star_seen       <= star_seen_next;
      prior_backslash <= (text_byte == CH_BACKSLASH);
    end
  end

endmodule

// ===== sv/bbc_depth_counter.sv =====
// Saturating nesting-depth counter for one bracket kind.
// Flags overflow at MAX_DEPTH and a closer at depth zero. Standalone; imports no package.
`timescale 1ns / 1ps

module bbc_depth_counter #(
  parameter int MAX_DEPTH = 255,
  parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               clear,
  input  logic               freeze,
  input  logic               open,
  input  logic               close,
  output logic [DEPTH_W-1:0] depth,
  output logic               nonzero_next,
  output logic               overflow,
  output logic               underflow
);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  logic [DEPTH_W-1:0] depth_next;

  always_comb begin
    depth_next = depth;
    overflow   = 1'b0;
    underflow  = 1'b0;
    if (!freeze) begin
      if (open) begin
        if (depth >= DEPTH_MAX) overflow = 1'b1;
        else depth_next = depth + DEPTH_W'(1);
      end else if (close) begin
        if (depth == '0) underflow = 1'b1;
        else depth_next = depth - DEPTH_W'(1);
      end
    end
    nonzero_next = (depth_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      depth <= '0;
    end else if (step) begin
      depth <= depth_next;
    end
  end

endmodule
